>>> rtl/pbfa_pkg.sv
package pbfa_pkg;

  // field widths
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned LIMIT_W = 21;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned EXT_W   = 22;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // page space size, one past the highest page frame number
  localparam logic [EXT_W-1:0] PAGE_SPACE = EXT_W'(1048576);

  // request kinds
  localparam logic [1:0] KIND_FREE   = 2'd0;
  localparam logic [1:0] KIND_MARK   = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;
  localparam logic [1:0] KIND_QUERY  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register index, taken from paddr bit 2
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  // shared divider widths
  localparam int unsigned DIV_NW = 20;
  localparam int unsigned DIV_DW = 13;
  localparam int unsigned DIV_CW = $clog2(DIV_NW + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/pbfa_div.sv
module pbfa_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pbfa_pkg::div_req_t req,
  output pbfa_pkg::div_rsp_t rsp
);
  import pbfa_pkg::*;

  logic [DIV_NW-1:0] shf_r, shf_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [DIV_DW:0] partial;
  logic [DIV_DW:0] diff;
  logic            ge;

  // one quotient bit per cycle, restoring
  assign partial = {rem_r, shf_r[DIV_NW-1]};
  assign diff    = partial - {1'b0, dsr_r};
  assign ge      = (partial >= {1'b0, dsr_r});

  always_comb begin
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      shf_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      cnt_nxt  = DIV_CW'(DIV_NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      shf_nxt = {shf_r[DIV_NW-2:0], ge};
      rem_nxt = ge ? diff[DIV_DW-1:0] : partial[DIV_DW-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    shf_r <= shf_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = shf_r;

endmodule

>>> rtl/page_bitmap_first_fit_allocator.sv
// Page allocation bitmap with aligned first-fit search.
// Input channel in_*: one request (kind, start_page, page_count, alignment),
// taken when in_valid is high and in_stall is low. in_stall is high whenever
// a request is in progress, so one request is handled at a time.
// Output channel out_*: exactly one result (status, found_page, page_in_use)
// per request, held in an output register until out_stall is low. A new
// request is taken while that result still waits; the next one finishes only
// once the register is free.
// Work per request: a range error or an empty range goes straight to the
// result; a query reads one bitmap word; a free or mark does one memory read
// and one write per bitmap word touched. A search tests each start candidate,
// scans its words and, when an allocated page is hit, takes the step to the
// next aligned start from a bit-serial divider with a 20-bit quotient; a free
// run is then marked word by word before the result is loaded. The next
// request is taken in the cycle after the result is loaded.
// Reset: base_page 0, limit_page 4096; then a clearing pass of one word per
// cycle sets every page allocated; requests wait until it ends, register
// writes are taken meanwhile.
// Registers: base_page at byte address 0, limit_page at byte address 4.
module page_bitmap_first_fit_allocator #(
  parameter int unsigned NUM_PAGES = 4096,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_kind,
  input  logic [pbfa_pkg::PAGE_W-1:0]   in_start_page,
  input  logic [pbfa_pkg::CNT_W-1:0]    in_page_count,
  input  logic [pbfa_pkg::CNT_W-1:0]    in_alignment,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [pbfa_pkg::PAGE_W-1:0]   out_found_page,
  output logic                          out_page_in_use,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pbfa_pkg::PADDR_W-1:0]  paddr,
  input  logic [pbfa_pkg::PDATA_W-1:0]  pwdata,
  output logic [pbfa_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import pbfa_pkg::*;

  localparam int unsigned MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SW  = $clog2(WORD_BITS);
  localparam int unsigned SHW = $clog2(WORD_BITS + 1);
  localparam logic [WORD_BITS-1:0] WALL = {WORD_BITS{1'b1}};

  typedef enum logic [7:0] {
    S_CLR  = 8'b00000001,
    S_IDLE = 8'b00000010,
    S_CAND = 8'b00000100,
    S_RD   = 8'b00001000,
    S_CHK  = 8'b00010000,
    S_ADIV = 8'b00100000,
    S_ADV  = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  // lowest set bit of a word
  function automatic logic [SW-1:0] low_idx(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] iso;
    logic [SW-1:0]        idx;
    iso = v & (~v + 1'b1);
    idx = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (iso[k]) idx = idx | SW'(k);
    end
    return idx;
  endfunction

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0]  base_r;
  logic [LIMIT_W-1:0] limit_r;

  logic [1:0]         kind_r, kind_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   align_r, align_nxt;
  logic [EXT_W-1:0]   n0_r, n0_nxt;
  logic [AW-1:0]      w0_r, w0_nxt;
  logic [SW-1:0]      s0_r, s0_nxt;
  logic [AW-1:0]      word_r, word_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   off_r, off_nxt;
  logic               fill_r, fill_nxt;
  logic [CNT_W:0]     prod_r, prod_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic [PAGE_W-1:0]  res_found_r, res_found_nxt;
  logic               res_use_r, res_use_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [PAGE_W-1:0]  out_found_r, out_found_nxt;
  logic               out_use_r, out_use_nxt;

  // bitmap memory
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] mem_q;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  pbfa_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // managed window end: min(limit, base + NUM_PAGES, page space)
  logic [EXT_W-1:0] win_cap, win_end;
  always_comb begin
    win_cap = EXT_W'(base_r) + EXT_W'(NUM_PAGES);
    win_end = EXT_W'(limit_r);
    if (win_cap < win_end) win_end = win_cap;
    if (win_end > PAGE_SPACE) win_end = PAGE_SPACE;
  end

  // request decode at the input
  logic [EXT_W-1:0] first_ext, rng_end, in_off;
  logic             lo_bad;
  assign first_ext = EXT_W'(in_start_page);
  assign rng_end   = first_ext + EXT_W'(in_page_count);
  assign in_off    = first_ext - EXT_W'(base_r);
  assign lo_bad    = (in_start_page < base_r);

  // candidate run end for the search
  logic [EXT_W-1:0] cand_end;
  assign cand_end = EXT_W'(base_r) + n0_r + EXT_W'(count_r);

  // mask of the bits of the current word that belong to the range
  logic [SHW-1:0]       avail, nb, hi_sh;
  logic [WORD_BITS-1:0] wmask, hits;
  logic                 last_word;
  logic [SW-1:0]        hit_idx;
  logic [CNT_W-1:0]     hit_off;
  always_comb begin
    avail     = SHW'(WORD_BITS) - SHW'(s_r);
    nb        = (rem_r < CNT_W'(avail)) ? rem_r[SHW-1:0] : avail;
    hi_sh     = avail - nb;
    wmask     = (WALL << s_r) & (WALL >> hi_sh);
    hits      = mem_q & wmask;
    last_word = (rem_r == CNT_W'(nb));
    hit_idx   = low_idx(hits);
    hit_off   = off_r + CNT_W'(hit_idx) - CNT_W'(s_r);
  end

  // step to the next aligned start: align * (quotient + 1)
  logic [CNT_W:0]       quot_inc;
  logic [2*CNT_W+1:0]   mul_full;
  assign quot_inc = {1'b0, div_rsp.quot[CNT_W-1:0]} + 1'b1;
  assign mul_full = {{(CNT_W+2){1'b0}}, align_r} * {{(CNT_W+1){1'b0}}, quot_inc};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    align_nxt      = align_r;
    n0_nxt         = n0_r;
    w0_nxt         = w0_r;
    s0_nxt         = s0_r;
    word_nxt       = word_r;
    s_nxt          = s_r;
    rem_nxt        = rem_r;
    off_nxt        = off_r;
    fill_nxt       = fill_r;
    prod_nxt       = prod_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_use_nxt    = res_use_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_use_nxt    = out_use_r;
    div_req        = '0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wa         = word_r;
    mem_wd         = mem_q;

    case (state_r)
      // fill every word with ones after reset
      S_CLR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_cnt_r;
        mem_wd      = WALL;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end

      // take a request and check the range of a free, mark or query
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt       = in_kind;
          count_nxt      = in_page_count;
          align_nxt      = (in_alignment == '0) ? CNT_W'(1) : in_alignment;
          fill_nxt       = 1'b0;
          res_status_nxt = ST_DONE;
          res_found_nxt  = '0;
          res_use_nxt    = 1'b0;
          n0_nxt         = in_off;
          // word and bit of the bitmap index, WORD_BITS a power of two
          word_nxt       = in_off[SW +: AW];
          s_nxt          = in_off[SW-1:0];
          w0_nxt         = in_off[SW +: AW];
          s0_nxt         = in_off[SW-1:0];
          off_nxt        = '0;
          rem_nxt        = (in_kind == KIND_QUERY) ? CNT_W'(1) : in_page_count;
          case (in_kind)
            KIND_FREE, KIND_MARK: begin
              if (lo_bad || rng_end > win_end) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_FIN;
              end else if (in_page_count == '0) begin
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_RD;
              end
            end
            KIND_SEARCH: begin
              n0_nxt         = '0;
              res_status_nxt = ST_NOFIT;
              state_nxt      = S_CAND;
            end
            KIND_QUERY: begin
              if (lo_bad || first_ext >= win_end) begin
                res_status_nxt = ST_RANGE;
                state_nxt      = S_FIN;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      // test one search start candidate
      S_CAND: begin
        if (cand_end > win_end) begin
          res_status_nxt = ST_NOFIT;
          state_nxt      = S_FIN;
        end else if (count_r == '0) begin
          res_status_nxt = ST_DONE;
          res_found_nxt  = base_r + n0_r[PAGE_W-1:0];
          state_nxt      = S_FIN;
        end else begin
          word_nxt  = n0_r[SW +: AW];
          s_nxt     = n0_r[SW-1:0];
          w0_nxt    = n0_r[SW +: AW];
          s0_nxt    = n0_r[SW-1:0];
          off_nxt   = '0;
          rem_nxt   = count_r;
          state_nxt = S_RD;
        end
      end

      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_CHK;
      end

      // work on one bitmap word
      S_CHK: begin
        if (kind_r == KIND_QUERY) begin
          res_use_nxt = mem_q[s_r];
          state_nxt   = S_FIN;
        end else if (kind_r == KIND_SEARCH && !fill_r) begin
          if (hits != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_NW'(hit_off);
            div_req.divisor  = align_r;
            state_nxt        = S_ADIV;
          end else if (last_word) begin
            // whole run free: go back and mark it
            fill_nxt  = 1'b1;
            word_nxt  = w0_r;
            s_nxt     = s0_r;
            rem_nxt   = count_r;
            off_nxt   = '0;
            state_nxt = S_RD;
          end else begin
            rem_nxt   = rem_r - CNT_W'(nb);
            off_nxt   = off_r + CNT_W'(nb);
            word_nxt  = word_r + 1'b1;
            s_nxt     = '0;
            state_nxt = S_RD;
          end
        end else begin
          mem_we = 1'b1;
          mem_wd = (kind_r == KIND_FREE) ? (mem_q & ~wmask) : (mem_q | wmask);
          if (last_word) begin
            if (kind_r == KIND_SEARCH) begin
              res_status_nxt = ST_DONE;
              res_found_nxt  = base_r + n0_r[PAGE_W-1:0];
            end
            state_nxt = S_FIN;
          end else begin
            rem_nxt   = rem_r - CNT_W'(nb);
            off_nxt   = off_r + CNT_W'(nb);
            word_nxt  = word_r + 1'b1;
            s_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end

      // skip distance past the allocated page
      S_ADIV: begin
        if (div_rsp.done) begin
          prod_nxt  = mul_full[CNT_W:0];
          state_nxt = S_ADV;
        end
      end

      S_ADV: begin
        n0_nxt    = n0_r + EXT_W'(prod_r);
        state_nxt = S_CAND;
      end

      // hand the result to the output register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_use_nxt    = res_use_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    count_r      <= count_nxt;
    align_r      <= align_nxt;
    n0_r         <= n0_nxt;
    w0_r         <= w0_nxt;
    s0_r         <= s0_nxt;
    word_r       <= word_nxt;
    s_r          <= s_nxt;
    rem_r        <= rem_nxt;
    off_r        <= off_nxt;
    fill_r       <= fill_nxt;
    prod_r       <= prod_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_use_r    <= res_use_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_use_r    <= out_use_nxt;
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // bitmap memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= map_mem[word_r];
  end

  // configuration registers
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      limit_r <= LIMIT_W'(4096);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_BASE:  base_r  <= pwdata[PAGE_W-1:0];
        REG_LIMIT: limit_r <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_BASE:  prdata = PDATA_W'(base_r);
      REG_LIMIT: prdata = PDATA_W'(limit_r);
      default:   prdata = '0;
    endcase
  end

  assign pready          = 1'b1;
  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_page  = out_found_r;
  assign out_page_in_use = out_use_r;

endmodule
